// ===== src/annexb_ns_pkg.sv =====
// ----------------------------------------------------------------------------
// annexb_ns_pkg
// Shared types and constants of the Annex B NAL unit splitter: payload
// structs, configuration struct, queue entry layout and field widths.
// ----------------------------------------------------------------------------
package annexb_ns_pkg;

    // width of the internal saturating unit length counter (8 to 32)
    localparam int LENGTH_WIDTH      = 24;
    // width of the unit length field in a descriptor
    localparam int UNIT_LENGTH_WIDTH = 24;

    localparam int PREFIX_WIDTH      = 3;
    localparam int TYPE_WIDTH        = 6;
    localparam int CLASS_WIDTH       = 2;

    // configuration port
    localparam int CFG_INDEX_WIDTH   = 2;
    localparam int CFG_DATA_WIDTH    = 8;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CODEC_MODE   = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FIRST_PREFIX = CFG_INDEX_WIDTH'(1);

    // longest start code prefix
    localparam logic [PREFIX_WIDTH-1:0] PREFIX_MAX   = PREFIX_WIDTH'(4);
    localparam logic [PREFIX_WIDTH-1:0] PREFIX_LONG  = PREFIX_WIDTH'(4);
    localparam logic [PREFIX_WIDTH-1:0] PREFIX_SHORT = PREFIX_WIDTH'(3);

    // parameter set class codes
    localparam logic [CLASS_WIDTH-1:0] CLASS_OTHER = CLASS_WIDTH'(0);
    localparam logic [CLASS_WIDTH-1:0] CLASS_VPS   = CLASS_WIDTH'(1);
    localparam logic [CLASS_WIDTH-1:0] CLASS_SPS   = CLASS_WIDTH'(2);
    localparam logic [CLASS_WIDTH-1:0] CLASS_PPS   = CLASS_WIDTH'(3);

    // nal types that select a parameter set class
    localparam logic [TYPE_WIDTH-1:0] AVC_SPS  = TYPE_WIDTH'(7);
    localparam logic [TYPE_WIDTH-1:0] AVC_PPS  = TYPE_WIDTH'(8);
    localparam logic [TYPE_WIDTH-1:0] HEVC_VPS = TYPE_WIDTH'(32);
    localparam logic [TYPE_WIDTH-1:0] HEVC_SPS = TYPE_WIDTH'(33);
    localparam logic [TYPE_WIDTH-1:0] HEVC_PPS = TYPE_WIDTH'(34);

    // queue between front and back
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } in_item_t;

    typedef struct packed {
        logic [UNIT_LENGTH_WIDTH-1:0] unit_length;
        logic [PREFIX_WIDTH-1:0]      prefix_length;
        logic [TYPE_WIDTH-1:0]        nal_type;
        logic [CLASS_WIDTH-1:0]       unit_class;
        logic                         length_saturated;
        logic                         header_seen;
        logic                         buffer_done;
        logic                         last_of_run;
    } out_item_t;

    typedef struct packed {
        logic                    codec_mode;
        logic [PREFIX_WIDTH-1:0] first_prefix_length;
    } cfg_t;

    // one unit descriptor before type decoding
    typedef struct packed {
        logic [UNIT_LENGTH_WIDTH-1:0] len;
        logic [PREFIX_WIDTH-1:0]      pfx;
        logic [7:0]                   hdr;
        logic                         hdr_seen;
        logic                         sat;
    } desc_t;

    // all descriptors caused by one byte: start code close, then buffer end
    typedef struct packed {
        logic  sc_valid;
        desc_t sc;
        logic  eob_valid;
        desc_t eob;
    } entry_t;

endpackage

// ===== src/annexb_ns_front.sv =====
// ----------------------------------------------------------------------------
// annexb_ns_front
// Byte scanner: tracks zero runs, unit length, prefix and header byte, and
// writes one queue entry for each byte that closes a unit.
// ----------------------------------------------------------------------------
module annexb_ns_front
    import annexb_ns_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  cfg_t     cfg,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    input  logic     q_full,
    output logic     q_push,
    output entry_t   q_entry
);

    localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = '1;

    logic [1:0]              zero_run_reg, zero_run_next;
    logic [LENGTH_WIDTH-1:0] count_reg, count_next;
    logic [PREFIX_WIDTH-1:0] prefix_reg, prefix_next;
    logic [PREFIX_WIDTH-1:0] skip_reg, skip_next;
    logic [7:0]              hdr_reg, hdr_next;
    logic                    hdr_valid_reg, hdr_valid_next;
    logic                    sat_reg, sat_next;

    logic accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // per-byte scan
    always_comb begin
        logic                    open;
        logic [PREFIX_WIDTH-1:0] clamp;
        logic [PREFIX_WIDTH-1:0] np;
        logic [LENGTH_WIDTH-1:0] body;
        logic [LENGTH_WIDTH-1:0] np_minus1;
        logic                    is_sc;
        logic                    count_it;

        open  = (count_reg == '0);
        clamp = (cfg.first_prefix_length > PREFIX_MAX) ? PREFIX_MAX
                                                        : cfg.first_prefix_length;

        // buffer start reloads the scan state
        zero_run_next  = open ? 2'd0 : zero_run_reg;
        count_next     = count_reg;
        prefix_next    = open ? clamp : prefix_reg;
        skip_next      = open ? clamp : skip_reg;
        hdr_next       = open ? 8'h00 : hdr_reg;
        hdr_valid_next = open ? 1'b0 : hdr_valid_reg;
        sat_next       = open ? 1'b0 : sat_reg;

        q_entry   = '0;
        count_it  = 1'b0;
        is_sc     = (skip_next == '0) && (s_data.data_byte == 8'h01)
                    && (zero_run_next >= 2'd2);
        np        = (zero_run_next == 2'd3) ? PREFIX_LONG : PREFIX_SHORT;
        np_minus1 = LENGTH_WIDTH'(np - PREFIX_WIDTH'(1));
        body      = count_next - LENGTH_WIDTH'(prefix_next);

        if (skip_next != '0) begin
            // assumed prefix bytes are counted, not scanned
            skip_next = skip_next - PREFIX_WIDTH'(1);
            count_it  = 1'b1;
        end else if (is_sc) begin
            // start code closes the current unit
            q_entry.sc_valid = 1'b1;
            q_entry.sc.pfx   = prefix_next;
            q_entry.sc.hdr   = hdr_next;
            q_entry.sc.sat   = sat_next;
            if (sat_next) begin
                q_entry.sc.len      = UNIT_LENGTH_WIDTH'(LEN_MAX);
                q_entry.sc.hdr_seen = hdr_valid_next;
            end else begin
                q_entry.sc.len      = UNIT_LENGTH_WIDTH'(count_next - np_minus1);
                q_entry.sc.hdr_seen = hdr_valid_next && (body > np_minus1);
            end
            count_next     = LENGTH_WIDTH'(np);
            prefix_next    = np;
            zero_run_next  = 2'd0;
            hdr_valid_next = 1'b0;
            hdr_next       = 8'h00;
            sat_next       = 1'b0;
        end else begin
            // unit body byte
            if (!hdr_valid_next) begin
                hdr_next       = s_data.data_byte;
                hdr_valid_next = 1'b1;
            end
            if (s_data.data_byte == 8'h00) begin
                if (zero_run_next != 2'd3) begin
                    zero_run_next = zero_run_next + 2'd1;
                end
            end else begin
                zero_run_next = 2'd0;
            end
            count_it = 1'b1;
        end

        // saturating length count
        if (count_it) begin
            if (count_next == LEN_MAX) begin
                sat_next = 1'b1;
            end else begin
                count_next = count_next + LENGTH_WIDTH'(1);
            end
        end

        // buffer end closes the last unit
        if (s_data.end_of_buffer) begin
            q_entry.eob_valid    = 1'b1;
            q_entry.eob.len      = sat_next ? UNIT_LENGTH_WIDTH'(LEN_MAX)
                                            : UNIT_LENGTH_WIDTH'(count_next);
            q_entry.eob.pfx      = prefix_next - skip_next;
            q_entry.eob.hdr      = hdr_next;
            q_entry.eob.hdr_seen = hdr_valid_next;
            q_entry.eob.sat      = sat_next;
            count_next           = '0;
        end

        q_push = accept && (q_entry.sc_valid || q_entry.eob_valid);
    end

    // scan state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_run_reg  <= 2'd0;
            count_reg     <= '0;
            prefix_reg    <= PREFIX_MAX;
            skip_reg      <= PREFIX_MAX;
            hdr_reg       <= 8'h00;
            hdr_valid_reg <= 1'b0;
            sat_reg       <= 1'b0;
        end else if (accept) begin
            zero_run_reg  <= zero_run_next;
            count_reg     <= count_next;
            prefix_reg    <= prefix_next;
            skip_reg      <= skip_next;
            hdr_reg       <= hdr_next;
            hdr_valid_reg <= hdr_valid_next;
            sat_reg       <= sat_next;
        end
    end

endmodule

// ===== src/annexb_ns_queue.sv =====
// ----------------------------------------------------------------------------
// annexb_ns_queue
// Small first-in first-out queue of descriptor entries between the scanner
// and the output side.
// ----------------------------------------------------------------------------
module annexb_ns_queue
    import annexb_ns_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output logic   empty,
    output entry_t head
);

    entry_t                     mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_WIDTH-1:0] cnt_reg, cnt_next;

    localparam logic [QUEUE_PTR_WIDTH-1:0] LAST_PTR = QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1);

    assign full  = (cnt_reg == QUEUE_CNT_WIDTH'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0
                                                   : wr_ptr_reg + QUEUE_PTR_WIDTH'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0
                                                   : rd_ptr_reg + QUEUE_PTR_WIDTH'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + QUEUE_CNT_WIDTH'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - QUEUE_CNT_WIDTH'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== src/annexb_ns_back.sv =====
// ----------------------------------------------------------------------------
// annexb_ns_back
// Output side: takes queue entries apart into single descriptors, decodes
// NAL type and class under the codec mode, and holds the result register.
// ----------------------------------------------------------------------------
module annexb_ns_back
    import annexb_ns_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      q_empty,
    input  entry_t    q_head,
    output logic      q_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic      valid_reg, valid_next;
    logic      second_reg, second_next;
    out_item_t data_reg, data_next;

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    // pick the next descriptor and decode its header
    always_comb begin
        logic  load;
        logic  take_sc;
        desc_t d;

        load        = !valid_reg || m_ready;
        valid_next  = valid_reg && !m_ready;
        second_next = second_reg;
        data_next   = data_reg;
        q_pop       = 1'b0;

        take_sc = q_head.sc_valid && !second_reg;
        d       = take_sc ? q_head.sc : q_head.eob;

        if (load && !q_empty) begin
            valid_next                 = 1'b1;
            data_next.unit_length      = d.len;
            data_next.prefix_length    = d.pfx;
            data_next.length_saturated = d.sat;
            data_next.header_seen      = d.hdr_seen;
            data_next.buffer_done      = !take_sc;
            data_next.last_of_run      = !(take_sc && q_head.eob_valid);
            data_next.nal_type         = '0;
            data_next.unit_class       = CLASS_OTHER;
            if (d.hdr_seen) begin
                if (cfg.codec_mode) begin
                    data_next.nal_type = d.hdr[6:1];
                    if (d.hdr[6:1] == HEVC_VPS) begin
                        data_next.unit_class = CLASS_VPS;
                    end else if (d.hdr[6:1] == HEVC_SPS) begin
                        data_next.unit_class = CLASS_SPS;
                    end else if (d.hdr[6:1] == HEVC_PPS) begin
                        data_next.unit_class = CLASS_PPS;
                    end
                end else begin
                    data_next.nal_type = {1'b0, d.hdr[4:0]};
                    if ({1'b0, d.hdr[4:0]} == AVC_SPS) begin
                        data_next.unit_class = CLASS_SPS;
                    end else if ({1'b0, d.hdr[4:0]} == AVC_PPS) begin
                        data_next.unit_class = CLASS_PPS;
                    end
                end
            end
            // hold the entry while its buffer end descriptor is still due
            if (take_sc && q_head.eob_valid) begin
                second_next = 1'b1;
            end else begin
                second_next = 1'b0;
                q_pop       = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end else begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

// ===== src/annexb_nal_unit_splitter_unit.sv =====
// ----------------------------------------------------------------------------
// annexb_nal_unit_splitter_unit
// Annex B start code parser for H.264 and H.265 streams: one descriptor per
// NAL unit with length, prefix length, type and parameter set class.
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle while s_ready is high. A byte that closes a
// unit writes one entry into a four-entry queue; the output side turns each
// entry into one descriptor per cycle while m_ready allows, so a byte that
// both ends a unit with a start code and ends the buffer yields two
// descriptors, and the queue keeps bytes flowing meanwhile. m_valid rises as
// the entry is loaded, unless earlier descriptors or back pressure hold the
// entry in the queue. Input ready drops only when the queue is full. Register
// 0 is codec_mode, applied as each descriptor leaves the queue; register 1 is
// first_prefix_length, taken at the next buffer start; writes are to be made
// while the block is idle. There is no clearing pass after reset.
module annexb_nal_unit_splitter_unit
    import annexb_ns_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  in_item_t                   s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output out_item_t                  m_data
);

    cfg_t   cfg_reg;
    logic   q_push, q_full, q_pop, q_empty;
    entry_t q_entry, q_head;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.codec_mode          <= 1'b0;
            cfg_reg.first_prefix_length <= PREFIX_MAX;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_CODEC_MODE) begin
                cfg_reg.codec_mode <= cfg_data[0];
            end else if (cfg_index == CFG_FIRST_PREFIX) begin
                cfg_reg.first_prefix_length <= cfg_data[PREFIX_WIDTH-1:0];
            end
        end
    end

    annexb_ns_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_entry)
    );

    annexb_ns_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .head       (q_head)
    );

    annexb_ns_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
